// ===== hw/rtl/lpe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexicographic permutation enumerator package
// Shared widths, cell control types and controller states.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int ELEM_W           = 3;
  localparam int POS_W            = 3;
  localparam int ORD_W            = 16;
  localparam int SIZE_W           = 4;
  localparam int DEF_MAX_ELEMENTS = 8;

  localparam logic [SIZE_W-1:0] RESET_TUPLE_SIZE = 4'd4;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [POS_W-1:0]  pos_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD_ID,
    CELL_SWAP,
    CELL_SORT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    pos_t     pivot_pos;
    pos_t     partner_pos;
    elem_t    pivot_val;
    elem_t    partner_val;
    logic     phase;
    pos_t     last_pos;
  } cell_ctl_t;

  typedef struct packed {
    logic asc;
    logic gt;
  } cell_flags_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_PARTNER,
    ST_SWAP,
    ST_SORT,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/lexicographic_permutation_enumerator_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexicographic permutation enumerator
// Streams permutations of 0..tuple_size-1 (clamped) in lexicographic order.
// ----------------------------------------------------------------------------
// Each transaction on the input returns one permutation with its ordinal and a
// last flag. A restart, the first request after reset or after a write of
// tuple_size, loads the identity and goes straight to the output step;
// wrapping from the last permutation to the identity passes the pivot search
// first. A normal advance has the accepting step, one step each to find the
// pivot, find its swap partner and swap them, then MAX_ELEMENTS odd-even
// exchange phases along the row of cells that sort the suffix, and a step to
// load the output register, which waits until the previous result is taken.
// The output register lets the next request be taken while a result waits.
module lexicographic_permutation_enumerator_unit #(
  parameter int MAX_ELEMENTS = lpe_pkg::DEF_MAX_ELEMENTS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_restart,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [MAX_ELEMENTS*lpe_pkg::ELEM_W-1:0] out_perm_elements,
  output logic [lpe_pkg::ORD_W-1:0]              out_perm_ordinal,
  output logic                                   out_is_last,
  input  logic                                   cfg_we,
  input  logic [lpe_pkg::SIZE_W-1:0]             cfg_wdata
);

  localparam int PERM_W = MAX_ELEMENTS * lpe_pkg::ELEM_W;

  lpe_pkg::state_t             state_r, state_nxt;
  logic                        started_r, started_nxt;
  logic [lpe_pkg::SIZE_W-1:0]  tuple_size_r, tuple_size_nxt;
  logic [lpe_pkg::ORD_W-1:0]   count_r, count_nxt;
  lpe_pkg::pos_t               pivot_pos_r, pivot_pos_nxt;
  lpe_pkg::elem_t              pivot_val_r, pivot_val_nxt;
  lpe_pkg::pos_t               partner_pos_r, partner_pos_nxt;
  lpe_pkg::elem_t              partner_val_r, partner_val_nxt;
  lpe_pkg::pos_t               sort_cnt_r, sort_cnt_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [PERM_W-1:0]           out_perm_r;
  logic [lpe_pkg::ORD_W-1:0]   out_ord_r;
  logic                        out_last_r;

  lpe_pkg::cell_op_t           cell_op;
  lpe_pkg::cell_ctl_t          ctl;
  lpe_pkg::pos_t               last_pos;
  lpe_pkg::elem_t              vals [MAX_ELEMENTS];
  lpe_pkg::cell_flags_t        flags [MAX_ELEMENTS];
  logic                        asc_found;
  lpe_pkg::pos_t               asc_pos;
  lpe_pkg::elem_t              asc_val;
  lpe_pkg::pos_t               gt_pos;
  lpe_pkg::elem_t              gt_val;
  logic                        any_asc;
  logic                        load_out;
  logic [PERM_W-1:0]           perm_packed;
  logic [MAX_ELEMENTS-1:0]     val_mask;

  always_comb begin
    if (tuple_size_r == '0) begin
      last_pos = '0;
    end else if (tuple_size_r > lpe_pkg::SIZE_W'(MAX_ELEMENTS)) begin
      last_pos = lpe_pkg::POS_W'(MAX_ELEMENTS - 1);
    end else begin
      last_pos = lpe_pkg::POS_W'(tuple_size_r - 1'b1);
    end
  end

  assign ctl.op          = cell_op;
  assign ctl.pivot_pos   = pivot_pos_r;
  assign ctl.partner_pos = partner_pos_r;
  assign ctl.pivot_val   = pivot_val_r;
  assign ctl.partner_val = partner_val_r;
  assign ctl.phase       = sort_cnt_r[0];
  assign ctl.last_pos    = last_pos;

  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    lpe_pkg::elem_t left_v;
    lpe_pkg::elem_t right_v;
    if (k == 0) begin : g_left_edge
      assign left_v = vals[k];
    end else begin : g_left
      assign left_v = vals[k-1];
    end
    if (k == MAX_ELEMENTS - 1) begin : g_right_edge
      assign right_v = vals[k];
    end else begin : g_right
      assign right_v = vals[k+1];
    end
    lpe_cell #(
      .INDEX(k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .left_i (left_v),
      .right_i(right_v),
      .val_o  (vals[k]),
      .flags_o(flags[k])
    );
  end

  always_comb begin
    asc_found   = 1'b0;
    asc_pos     = '0;
    asc_val     = '0;
    gt_pos      = '0;
    gt_val      = '0;
    perm_packed = '0;
    val_mask    = '0;
    for (int k = 0; k < MAX_ELEMENTS; k++) begin
      if (flags[k].asc) begin
        asc_found = 1'b1;
        asc_pos   = lpe_pkg::POS_W'(k);
        asc_val   = vals[k];
      end
      if (flags[k].gt) begin
        gt_pos = lpe_pkg::POS_W'(k);
        gt_val = vals[k];
      end
      if (lpe_pkg::POS_W'(k) <= last_pos) begin
        perm_packed[k*lpe_pkg::ELEM_W +: lpe_pkg::ELEM_W] = vals[k];
      end
      val_mask[vals[k]] = 1'b1;
    end
  end

  assign any_asc = asc_found;

  always_comb begin
    state_nxt       = state_r;
    started_nxt     = started_r;
    tuple_size_nxt  = tuple_size_r;
    count_nxt       = count_r;
    pivot_pos_nxt   = pivot_pos_r;
    pivot_val_nxt   = pivot_val_r;
    partner_pos_nxt = partner_pos_r;
    partner_val_nxt = partner_val_r;
    sort_cnt_nxt    = sort_cnt_r;
    cell_op         = lpe_pkg::CELL_HOLD;
    load_out        = 1'b0;
    case (state_r)
      lpe_pkg::ST_IDLE: begin
        if (in_valid) begin
          started_nxt = 1'b1;
          if (in_restart || !started_r) begin
            cell_op   = lpe_pkg::CELL_LOAD_ID;
            count_nxt = '0;
            state_nxt = lpe_pkg::ST_EMIT;
          end else begin
            state_nxt = lpe_pkg::ST_PIVOT;
          end
        end
      end
      lpe_pkg::ST_PIVOT: begin
        if (asc_found) begin
          pivot_pos_nxt = asc_pos;
          pivot_val_nxt = asc_val;
          state_nxt     = lpe_pkg::ST_PARTNER;
        end else begin
          cell_op   = lpe_pkg::CELL_LOAD_ID;
          count_nxt = '0;
          state_nxt = lpe_pkg::ST_EMIT;
        end
      end
      lpe_pkg::ST_PARTNER: begin
        partner_pos_nxt = gt_pos;
        partner_val_nxt = gt_val;
        state_nxt       = lpe_pkg::ST_SWAP;
      end
      lpe_pkg::ST_SWAP: begin
        cell_op      = lpe_pkg::CELL_SWAP;
        sort_cnt_nxt = '0;
        state_nxt    = lpe_pkg::ST_SORT;
      end
      lpe_pkg::ST_SORT: begin
        cell_op      = lpe_pkg::CELL_SORT;
        sort_cnt_nxt = sort_cnt_r + 1'b1;
        if (sort_cnt_r == lpe_pkg::POS_W'(MAX_ELEMENTS - 1)) begin
          count_nxt = count_r + 1'b1;
          state_nxt = lpe_pkg::ST_EMIT;
        end
      end
      lpe_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = lpe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lpe_pkg::ST_IDLE;
      end
    endcase
    if (cfg_we) begin
      tuple_size_nxt = cfg_wdata;
      cell_op        = lpe_pkg::CELL_LOAD_ID;
      count_nxt      = '0;
      started_nxt    = 1'b0;
    end
  end

  assign in_ready = (state_r == lpe_pkg::ST_IDLE);

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lpe_pkg::ST_IDLE;
      started_r    <= 1'b0;
      tuple_size_r <= lpe_pkg::RESET_TUPLE_SIZE;
      count_r      <= '0;
      sort_cnt_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      started_r    <= started_nxt;
      tuple_size_r <= tuple_size_nxt;
      count_r      <= count_nxt;
      sort_cnt_r   <= sort_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pivot_pos_r   <= pivot_pos_nxt;
    pivot_val_r   <= pivot_val_nxt;
    partner_pos_r <= partner_pos_nxt;
    partner_val_r <= partner_val_nxt;
    if (load_out) begin
      out_perm_r <= perm_packed;
      out_ord_r  <= count_r;
      out_last_r <= !any_asc;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_perm_elements = out_perm_r;
  assign out_perm_ordinal  = out_ord_r;
  assign out_is_last       = out_last_r;

  a_cells_permutation: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(val_mask) == MAX_ELEMENTS)
    else $error("Cell values no longer form a permutation.");

  a_ordinal_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpe_pkg::ST_EMIT && $past(state_r) == lpe_pkg::ST_SORT) |->
      count_r == $past(count_r) + 1'b1)
    else $error("Ordinal did not advance by one after a sort.");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r != lpe_pkg::ST_IDLE)
    else $error("Controller stayed idle after an input transaction.");

  a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lpe_pkg::ST_SWAP) |-> (pivot_val_r < partner_val_r) &&
      (pivot_pos_r < partner_pos_r))
    else $error("Swap partner is not a larger element right of the pivot.");

endmodule

// ===== hw/rtl/lpe_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Permutation cell
// Holds one element, loads its index or joins the pivot swap, and exchanges it with its neighbors during the sort.
// ----------------------------------------------------------------------------
module lpe_cell #(
  parameter int INDEX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lpe_pkg::cell_ctl_t  ctl_i,
  input  lpe_pkg::elem_t      left_i,
  input  lpe_pkg::elem_t      right_i,
  output lpe_pkg::elem_t      val_o,
  output lpe_pkg::cell_flags_t flags_o
);

  localparam logic [lpe_pkg::POS_W:0] IDX = (lpe_pkg::POS_W + 1)'(INDEX);

  lpe_pkg::elem_t          val_r;
  lpe_pkg::elem_t          val_nxt;
  logic [lpe_pkg::POS_W:0] piv;
  logic [lpe_pkg::POS_W:0] last;
  logic                    right_act;
  logic                    left_act;

  assign piv  = {1'b0, ctl_i.pivot_pos};
  assign last = {1'b0, ctl_i.last_pos};

  assign right_act = (IDX > piv) && (IDX < last) && (IDX[0] == ctl_i.phase) &&
                     (val_r > right_i);
  assign left_act  = (IDX > piv + 1'b1) && (IDX <= last) && (IDX[0] != ctl_i.phase) &&
                     (left_i > val_r);

  always_comb begin
    val_nxt = val_r;
    case (ctl_i.op)
      lpe_pkg::CELL_HOLD: begin
        val_nxt = val_r;
      end
      lpe_pkg::CELL_LOAD_ID: begin
        val_nxt = lpe_pkg::ELEM_W'(INDEX);
      end
      lpe_pkg::CELL_SWAP: begin
        if (IDX == piv) begin
          val_nxt = ctl_i.partner_val;
        end else if (IDX == {1'b0, ctl_i.partner_pos}) begin
          val_nxt = ctl_i.pivot_val;
        end
      end
      lpe_pkg::CELL_SORT: begin
        if (right_act) begin
          val_nxt = right_i;
        end else if (left_act) begin
          val_nxt = left_i;
        end
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= lpe_pkg::ELEM_W'(INDEX);
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val_o       = val_r;
  assign flags_o.asc = (IDX < last) && (val_r < right_i);
  assign flags_o.gt  = (IDX > piv) && (IDX <= last) && (val_r > ctl_i.pivot_val);

endmodule

// ===== bench/lexicographic_permutation_enumerator_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lexicographic permutation enumerator testbench
// Sends request transactions with random restarts over a range of tuple sizes,
// the out-of-range ones included, under several idling patterns and one long
// receiver hold-off. Each result transaction is checked in order against a
// local next-permutation predictor for elements, ordinal and last flag.
// ----------------------------------------------------------------------------
module lexicographic_permutation_enumerator_unit_tb;

  localparam int MAXE        = lpe_pkg::DEF_MAX_ELEMENTS;
  localparam int PERM_W      = MAXE * lpe_pkg::ELEM_W;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int PRINT_CAP   = 100;
  localparam int PHASES      = 17;
  localparam logic [PHASES-1:0][lpe_pkg::SIZE_W-1:0] SIZE_PLAN = {
    4'd1, 4'd7, 4'd4, 4'd0, 4'd3, 4'd5, 4'd2, 4'd6, 4'd8,
    4'd9, 4'd15, 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0
  };

  typedef struct packed {
    logic [PERM_W-1:0]         elements;
    logic [lpe_pkg::ORD_W-1:0] ordinal;
    logic                      last;
  } perm_result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic                       in_restart = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [PERM_W-1:0]          out_perm_elements;
  logic [lpe_pkg::ORD_W-1:0]  out_perm_ordinal;
  logic                       out_is_last;
  logic                       cfg_we = 1'b0;
  logic [lpe_pkg::SIZE_W-1:0] cfg_wdata = '0;

  bit                         request_q[$];
  perm_result_t               perm_q[$];
  lpe_pkg::elem_t             model_perm[MAXE];
  logic [lpe_pkg::ORD_W-1:0]  model_ordinal;
  bit                         model_started;
  logic [lpe_pkg::SIZE_W-1:0] model_size;
  int                         send_idle_pct = 0;
  int                         recv_stall_pct = 0;
  int                         hold_requests = 0;
  int                         hold_served = 0;
  int                         hold_left = 0;
  int                         idle_cycles = 0;
  int                         errors = 0;

  lexicographic_permutation_enumerator_unit #(
    .MAX_ELEMENTS(MAXE)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_perm_elements(out_perm_elements),
    .out_perm_ordinal (out_perm_ordinal),
    .out_is_last      (out_is_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void load_identity();
    for (int k = 0; k < MAXE; k++) model_perm[k] = lpe_pkg::elem_t'(k);
    model_ordinal = '0;
  endfunction

  function automatic perm_result_t next_permutation(bit restart);
    int             n;
    int             pivot;
    int             partner;
    bit             found;
    bit             descending;
    lpe_pkg::elem_t swapped[MAXE];
    perm_result_t   res;
    if (model_size == 0) n = 1;
    else if (model_size > MAXE) n = MAXE;
    else n = int'(model_size);
    found = 1'b0;
    pivot = 0;
    partner = 0;
    for (int k = 0; k + 1 < n; k++) begin
      if (model_perm[k] < model_perm[k + 1]) begin
        found = 1'b1;
        pivot = k;
      end
    end
    if (restart || !model_started || !found) begin
      load_identity();
    end else begin
      for (int k = pivot + 1; k < n; k++) begin
        if (model_perm[k] > model_perm[pivot]) partner = k;
      end
      for (int k = 0; k < MAXE; k++) swapped[k] = model_perm[k];
      swapped[pivot] = model_perm[partner];
      swapped[partner] = model_perm[pivot];
      model_perm[pivot] = swapped[pivot];
      for (int k = pivot + 1; k < n; k++) model_perm[k] = swapped[n + pivot - k];
      model_ordinal = model_ordinal + 1'b1;
    end
    model_started = 1'b1;
    res.elements = '0;
    descending = 1'b1;
    for (int k = 0; k < n; k++) begin
      res.elements[k*lpe_pkg::ELEM_W +: lpe_pkg::ELEM_W] = model_perm[k];
      if (k + 1 < n && model_perm[k] < model_perm[k + 1]) descending = 1'b0;
    end
    res.ordinal = model_ordinal;
    res.last = descending;
    return res;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (errors < PRINT_CAP)
      $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
    errors++;
  endtask

  task automatic write_tuple_size(logic [lpe_pkg::SIZE_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    model_size = value;
    load_identity();
    model_started = 1'b0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (request_q.size() != 0 || in_valid || perm_q.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin : drive_requests
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_restart <= 1'b0;
    end else begin
      if (in_valid && in_ready) perm_q.push_back(next_permutation(in_restart));
      if (!in_valid || in_ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_restart <= request_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : collect_results
    perm_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (perm_q.size() == 0) begin
          report_mismatch("unexpected transaction", 32'(out_perm_ordinal), 32'd0);
        end else begin
          want = perm_q.pop_front();
          if (out_perm_elements !== want.elements)
            report_mismatch("perm_elements", 32'(out_perm_elements), 32'(want.elements));
          if (out_perm_ordinal !== want.ordinal)
            report_mismatch("perm_ordinal", 32'(out_perm_ordinal), 32'(want.ordinal));
          if (out_is_last !== want.last)
            report_mismatch("is_last", 32'(out_is_last), 32'(want.last));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("lexicographic_permutation_enumerator_unit_tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin : run_test
    int mode;
    int n;
    int count;
    model_size = lpe_pkg::RESET_TUPLE_SIZE;
    load_identity();
    model_started = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First request with restart low, an explicit restart, then a full
    // walk of the reset size through its last permutation and the wrap.
    request_q.push_back(1'b0);
    request_q.push_back(1'b1);
    repeat (24) request_q.push_back(1'b0);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      write_tuple_size(SIZE_PLAN[p]);
      @(negedge clk);
      mode = p % 4;
      send_idle_pct = (mode == 1) ? 75 : (mode == 3) ? 9 : 0;
      recv_stall_pct = (mode == 2) ? 75 : (mode == 3) ? 9 : 0;
      if (SIZE_PLAN[p] == 6) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests++;
      end
      if (SIZE_PLAN[p] == 0) n = 1;
      else if (SIZE_PLAN[p] > MAXE) n = MAXE;
      else n = int'(SIZE_PLAN[p]);
      count = 1;
      for (int k = 2; k <= n; k++) count = count * k;
      if (n <= 6) count = count + int'($urandom_range(2, 20));
      else count = 120;
      request_q.push_back(1'($urandom_range(1)));
      repeat (count - 1) request_q.push_back($urandom_range(49) == 0);
      wait_drained();
    end

    repeat (30) @(posedge clk);
    if (errors == 0) begin
      $display("lexicographic_permutation_enumerator_unit_tb OK");
    end else begin
      $display("lexicographic_permutation_enumerator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
